FILE: src/decimal_text_to_fixed_point_defines.svh
// Assertion macros shared by the decimal text to fixed-point converter.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`ifndef SYNTH
`define DTFP_ASSERT_ALWAYS(label, clock, resetn, cond) \
  label: assert property (@(posedge clock) disable iff (!(resetn)) (cond)) \
    else $error("dtfp assertion failed");
`define DTFP_ASSERT_NEXT(label, clock, resetn, pre, post) \
  label: assert property (@(posedge clock) disable iff (!(resetn)) (pre) |=> (post)) \
    else $error("dtfp assertion failed");
`else
`define DTFP_ASSERT_ALWAYS(label, clock, resetn, cond)
`define DTFP_ASSERT_NEXT(label, clock, resetn, pre, post)
`endif
`endif

FILE: src/dtfp_pkg.sv
// Character codes, limits and pipeline types of the decimal text converter.
package dtfp_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic MODE_DOT_POINT   = 1'b0;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        sat;
    logic        bad;
  } fin_t;

endpackage

FILE: src/decimal_text_to_fixed_point.sv
// Top level of the decimal text to signed fixed-point converter.
//
// Channel   Direction  Request contents
// in_       input      in_character (8 bits), in_last (1 bit)
// out_      output     out_value (64 bits signed), out_invalid, out_overflow
// APB       config     format_mode at byte address 0 (paddr[2] low)
//
// One character is taken in every cycle unless in_stall is high; the parse state updates in one pass.
// A result passes through a finish register, then the output register that
// holds the saturation and sign stage.
// Reset is synchronous and active low and returns the parse to its start.
// A stalled result holds the output; input stalls only when both stages are full.
`include "decimal_text_to_fixed_point_defines.svh"

module decimal_text_to_fixed_point #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_character,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_invalid,
  output logic               out_overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W   = $clog2(FRACTION_DIGITS + 1);
  localparam int W_DEPTH = 2 ** CNT_W;

  function automatic logic [31:0] pow10(input int n);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < n; i++) begin
      r = 32'(r * 32'd10);
    end
    return r;
  endfunction

  localparam logic [31:0] SCALE = pow10(FRACTION_DIGITS);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WHOLE,
    PH_FRAC,
    PH_DONE,
    PH_BAD
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               sat_r, sat_nxt;
  logic               mode_r;

  dtfp_pkg::fin_t     fin_r;
  logic               fin_valid_r;
  logic               out_valid_r;
  logic [63:0]        out_value_r;
  logic               out_invalid_r;
  logic               out_overflow_r;

  logic               in_acc;
  logic               fin_adv;
  logic               out_adv;
  logic               is_digit;
  logic [3:0]         digit_val;
  logic [67:0]        whole_sum;
  logic [64:0]        frac_sum;
  logic [31:0]        frac_weight [W_DEPTH];
  logic               ovf;

  for (genvar i = 0; i < W_DEPTH; i++) begin : g_weight
    if (i < FRACTION_DIGITS) begin : g_used
      assign frac_weight[i] = pow10(FRACTION_DIGITS - 1 - i);
    end else begin : g_unused
      assign frac_weight[i] = 32'd0;
    end
  end

  assign pready = 1'b1;
  assign prdata = {31'd0, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dtfp_pkg::MODE_DOT_POINT;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mode_r <= pwdata[0];
    end
  end

  assign out_adv  = !out_valid_r || !out_stall;
  assign fin_adv  = !fin_valid_r || out_adv;
  assign in_stall = !fin_adv;
  assign in_acc   = in_valid && !in_stall;

  assign is_digit  = (in_character >= dtfp_pkg::CHAR_ZERO) &&
                     (in_character <= dtfp_pkg::CHAR_NINE);
  assign digit_val = 4'(in_character - dtfp_pkg::CHAR_ZERO);
  assign whole_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                     68'(36'(digit_val) * 36'(SCALE));
  assign frac_sum  = {1'b0, acc_r} + 65'(36'(digit_val) * 36'(frac_weight[cnt_r]));

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    if (phase_r == PH_LEAD || phase_r == PH_WHOLE || phase_r == PH_FRAC) begin
      if (in_character == dtfp_pkg::CHAR_NUL) begin
        phase_nxt = PH_DONE;
      end else if (phase_r == PH_LEAD && (in_character == dtfp_pkg::CHAR_SPACE ||
                                          in_character == dtfp_pkg::CHAR_TAB)) begin
        phase_nxt = PH_LEAD;
      end else if (phase_r == PH_LEAD && in_character == dtfp_pkg::CHAR_MINUS) begin
        neg_nxt   = 1'b1;
        phase_nxt = PH_WHOLE;
      end else if (phase_r == PH_LEAD && in_character == dtfp_pkg::CHAR_PLUS) begin
        phase_nxt = PH_WHOLE;
      end else if (phase_r != PH_FRAC) begin
        phase_nxt = PH_WHOLE;
        if (is_digit) begin
          if (!sat_r) begin
            if (whole_sum > {4'd0, dtfp_pkg::TOP_BIT}) begin
              sat_nxt = 1'b1;
            end else begin
              acc_nxt = whole_sum[63:0];
            end
          end
        end else if (mode_r == dtfp_pkg::MODE_DOT_POINT) begin
          phase_nxt = (in_character == dtfp_pkg::CHAR_DOT) ? PH_FRAC : PH_DONE;
        end else if (in_character == dtfp_pkg::CHAR_COMMA) begin
          phase_nxt = PH_FRAC;
        end else if (in_character != dtfp_pkg::CHAR_DOT) begin
          phase_nxt = PH_BAD;
        end
      end else begin
        if (is_digit && cnt_r < CNT_W'(FRACTION_DIGITS)) begin
          if (!sat_r) begin
            if (frac_sum > {1'b0, dtfp_pkg::TOP_BIT}) begin
              sat_nxt = 1'b1;
            end else begin
              acc_nxt = frac_sum[63:0];
            end
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_nxt >= CNT_W'(FRACTION_DIGITS)) begin
            phase_nxt = PH_DONE;
          end
        end else begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      acc_r   <= 64'd0;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
      sat_r   <= 1'b0;
    end else if (in_acc) begin
      if (in_last) begin
        phase_r <= PH_LEAD;
        acc_r   <= 64'd0;
        cnt_r   <= '0;
        neg_r   <= 1'b0;
        sat_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        neg_r   <= neg_nxt;
        sat_r   <= sat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_adv) begin
      fin_valid_r <= in_acc && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      fin_r.mag <= acc_nxt;
      fin_r.neg <= neg_nxt;
      fin_r.sat <= sat_nxt;
      fin_r.bad <= (phase_nxt == PH_BAD);
    end
  end

  assign ovf = fin_r.sat ||
               (fin_r.neg ? (fin_r.mag > dtfp_pkg::TOP_BIT)
                          : (fin_r.mag > dtfp_pkg::POS_LIMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      if (fin_r.bad) begin
        out_value_r    <= 64'd0;
        out_invalid_r  <= 1'b1;
        out_overflow_r <= 1'b0;
      end else begin
        if (ovf) begin
          out_value_r <= fin_r.neg ? dtfp_pkg::TOP_BIT : dtfp_pkg::POS_LIMIT;
        end else begin
          out_value_r <= fin_r.neg ? (64'd0 - fin_r.mag) : fin_r.mag;
        end
        out_invalid_r  <= 1'b0;
        out_overflow_r <= ovf;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_invalid  = out_invalid_r;
  assign out_overflow = out_overflow_r;

  `DTFP_ASSERT_ALWAYS(a_invalid_zero, clk, rst_n,
    !(out_valid && out_invalid) || (out_value == 64'sd0 && !out_overflow))
  `DTFP_ASSERT_ALWAYS(a_overflow_limit, clk, rst_n,
    !(out_valid && out_overflow) || (out_value == dtfp_pkg::TOP_BIT ||
                                     out_value == dtfp_pkg::POS_LIMIT))
  `DTFP_ASSERT_ALWAYS(a_acc_bounded, clk, rst_n, acc_r <= dtfp_pkg::TOP_BIT)
  `DTFP_ASSERT_NEXT(a_last_finishes, clk, rst_n, in_acc && in_last, fin_valid_r)
  `DTFP_ASSERT_NEXT(a_last_clears, clk, rst_n, in_acc && in_last,
    phase_r == PH_LEAD && acc_r == 64'd0 && !sat_r && !neg_r)

endmodule
